@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OWBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owbm assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owbm assertion failed");

`endif

@@ design/owbm_pkg.sv @@
package owbm_pkg;

  localparam int CFG_W     = 10;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SMPL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_TOTAL     = 3'd7;

  localparam logic [CFG_W-1:0] REG_INIT [NUM_REGS] = '{
    10'd480, 10'd65, 10'd416, 10'd11, 10'd70, 10'd1, 10'd15, 10'd72
  };

  localparam logic [1:0] FUNC_RESET = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [1:0] STATUS_PRESENT = 2'd0;
  localparam logic [1:0] STATUS_NO_DEV  = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  // reflected form of x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_RLOW  = 6'b000010,
    PH_RWAIT = 6'b000100,
    PH_RTAIL = 6'b001000,
    PH_WRITE = 6'b010000,
    PH_READ  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       line_in;
  } in_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
    logic [7:0] crc_value;
  } out_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ data[k]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/one_wire_bus_master.sv @@
// 1-Wire bus master. Each transaction on the input channel is one bus timing tick: it
// carries the sampled line level and optionally a command (reset/presence, write byte,
// read byte, all LSB first). Exactly one result follows each input, with that tick's
// line drive, busy/done flags, the last read byte, the last reset status and a running
// Dallas CRC-8 over read bytes (cleared by a bus reset). One tick is accepted every
// clock cycle; the input stalls only while out_stall holds a result. The path per tick
// is the slot timer compare plus the 8-step CRC fold. The user must set slot timings
// through the cfg port only while no command is in progress, unchecked by the block.
module one_wire_bus_master #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  owbm_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output owbm_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owbm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
  localparam logic [TIMER_WIDTH-1:0] ONE  = TIMER_WIDTH'(1);

  logic [TIMER_WIDTH-1:0] lim [owbm_pkg::NUM_REGS];

  owbm_pkg::phase_t       phase_r, phase_nxt, eph;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt, n;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic [7:0]             crc_r, crc_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   out_valid_r;
  owbm_pkg::out_t         out_data_r, res;

  logic                   accept;
  logic                   start_write;
  logic                   span_end;
  logic [TIMER_WIDTH-1:0] span_len, slot, se, sp, wr_low;
  logic [7:0]             rx_shift_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign start_write = accept && phase_r == owbm_pkg::PH_IDLE && in_data.cmd_valid &&
                       in_data.func == owbm_pkg::FUNC_WRITE;

  owbm_regs #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .lim_o    (lim)
  );

  always_comb begin
    eph        = phase_r;
    n          = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    rx_nxt     = rx_r;
    crc_nxt    = crc_r;
    status_nxt = status_r;
    res        = '0;

    // command start
    if (phase_r == owbm_pkg::PH_IDLE && in_data.cmd_valid &&
        in_data.func != owbm_pkg::FUNC_NONE) begin
      n       = '0;
      bit_nxt = '0;
      if (in_data.func == owbm_pkg::FUNC_RESET) begin
        eph     = owbm_pkg::PH_RLOW;
        crc_nxt = '0;
      end else if (in_data.func == owbm_pkg::FUNC_WRITE) begin
        eph       = owbm_pkg::PH_WRITE;
        shift_nxt = in_data.tx_byte;
      end else begin
        eph       = owbm_pkg::PH_READ;
        shift_nxt = '0;
      end
    end

    slot = lim[owbm_pkg::REG_SLOT_TOTAL];
    se   = (slot == '0) ? ONE : slot;
    sp   = (lim[owbm_pkg::REG_READ_SAMPLE] < se) ? lim[owbm_pkg::REG_READ_SAMPLE] : se - ONE;
    wr_low = shift_nxt[0] ? lim[owbm_pkg::REG_WRITE_ONE_LOW] :
                            lim[owbm_pkg::REG_WRITE_ZERO_LOW];

    unique case (eph)
      owbm_pkg::PH_RLOW:  span_len = lim[owbm_pkg::REG_RESET_LOW];
      owbm_pkg::PH_RWAIT: span_len = lim[owbm_pkg::REG_PRESENCE_SMPL];
      owbm_pkg::PH_RTAIL: span_len = lim[owbm_pkg::REG_RESET_TAIL];
      default:            span_len = slot;
    endcase
    span_end = ({1'b0, n} + {{TIMER_WIDTH{1'b0}}, 1'b1}) >= {1'b0, span_len};

    phase_nxt    = eph;
    tick_nxt     = (n < TMAX) ? n + ONE : n;
    rx_shift_new = {in_data.line_in, shift_nxt[7:1]};
    res.busy_res = (eph != owbm_pkg::PH_IDLE);

    unique case (eph)
      owbm_pkg::PH_IDLE: begin
        tick_nxt = tick_r;
      end
      owbm_pkg::PH_RLOW: begin
        res.line_low = 1'b1;
        if (span_end) begin
          phase_nxt = owbm_pkg::PH_RWAIT;
          tick_nxt  = '0;
        end
      end
      owbm_pkg::PH_RWAIT: begin
        if (span_end) begin
          tick_nxt = '0;
          if (in_data.line_in) begin
            status_nxt   = owbm_pkg::STATUS_NO_DEV;
            res.done_res = 1'b1;
            phase_nxt    = owbm_pkg::PH_IDLE;
          end else begin
            phase_nxt = owbm_pkg::PH_RTAIL;
          end
        end
      end
      owbm_pkg::PH_RTAIL: begin
        if (span_end) begin
          status_nxt   = in_data.line_in ? owbm_pkg::STATUS_PRESENT : owbm_pkg::STATUS_SHORT;
          res.done_res = 1'b1;
          phase_nxt    = owbm_pkg::PH_IDLE;
          tick_nxt     = '0;
        end
      end
      owbm_pkg::PH_WRITE: begin
        res.line_low = (n < wr_low);
        if (span_end) begin
          shift_nxt = shift_nxt >> 1;
          tick_nxt  = '0;
          if (bit_nxt == 3'd7) begin
            res.done_res = 1'b1;
            phase_nxt    = owbm_pkg::PH_IDLE;
            bit_nxt      = '0;
          end else begin
            bit_nxt = bit_nxt + 3'd1;
          end
        end
      end
      owbm_pkg::PH_READ: begin
        res.line_low = (n < lim[owbm_pkg::REG_READ_LOW]);
        if (n == sp) begin
          shift_nxt = rx_shift_new;
        end
        if (span_end) begin
          tick_nxt = '0;
          if (bit_nxt == 3'd7) begin
            rx_nxt       = shift_nxt;
            crc_nxt      = owbm_pkg::crc_fold(crc_nxt, shift_nxt);
            res.done_res = 1'b1;
            phase_nxt    = owbm_pkg::PH_IDLE;
            bit_nxt      = '0;
          end else begin
            bit_nxt = bit_nxt + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = owbm_pkg::PH_IDLE;
        tick_nxt  = tick_r;
      end
    endcase

    res.rx_byte   = rx_nxt;
    res.status    = status_nxt;
    res.crc_value = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owbm_pkg::PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      crc_r       <= '0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        rx_r     <= rx_nxt;
        crc_r    <= crc_nxt;
        status_r <= status_nxt;
      end
      out_valid_r <= accept | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

`include "assert_macros.svh"

  `OWBM_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_r))
  `OWBM_ASSERT_NOW(a_done_busy, out_valid_r && out_data_r.done_res, out_data_r.busy_res)
  `OWBM_ASSERT_NEXT(a_write_start, start_write, phase_r == owbm_pkg::PH_WRITE)
  `OWBM_ASSERT_NOW(a_idle_bit0, phase_r == owbm_pkg::PH_IDLE, bit_r == 3'd0)

endmodule

@@ design/owbm_regs.sv @@
module owbm_regs #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [owbm_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [owbm_pkg::CFG_W-1:0]         wr_data,
  output logic [TIMER_WIDTH-1:0]             lim_o [owbm_pkg::NUM_REGS]
);

  localparam int LW = (TIMER_WIDTH > owbm_pkg::CFG_W) ? TIMER_WIDTH : owbm_pkg::CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic [owbm_pkg::CFG_W-1:0] regs_r [owbm_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
        regs_r[i] <= owbm_pkg::REG_INIT[i];
      end
    end else if (wr_en) begin
      regs_r[wr_index] <= wr_data;
    end
  end

  // durations saturate at the timer range
  always_comb begin
    for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
      if (LW'(regs_r[i]) > LW'(TMAX)) begin
        lim_o[i] = TMAX;
      end else begin
        lim_o[i] = TIMER_WIDTH'(LW'(regs_r[i]));
      end
    end
  end

endmodule

@@ tb/one_wire_bus_master_tb.sv @@
module one_wire_bus_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS = 1150;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NROWS = 18;
  localparam owbm_pkg::out_t QUIET = '0;

  typedef enum logic [1:0] {LINE_HIGH, LINE_LOW, LINE_PULSE, LINE_RAND} line_mode_t;

  typedef struct {
    owbm_pkg::in_t  first;
    line_mode_t     mode;
    bit             poke;
    bit             typed;
    owbm_pkg::out_t want;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  owbm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  owbm_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [owbm_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [owbm_pkg::CFG_W-1:0] cfg_data = '0;

  one_wire_bus_master u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bus master state as the testbench sees it
  logic [owbm_pkg::CFG_W-1:0] timing_regs [owbm_pkg::NUM_REGS] = owbm_pkg::REG_INIT;
  logic [owbm_pkg::CFG_W-1:0] timing_next [owbm_pkg::NUM_REGS];
  owbm_pkg::phase_t bus_phase = owbm_pkg::PH_IDLE;
  logic [9:0] slot_cnt = '0;
  logic [2:0] bit_cnt = '0;
  logic [7:0] shift_q = '0;
  logic [7:0] rx_q = '0;
  logic [7:0] crc_q = '0;
  logic [1:0] status_q = owbm_pkg::STATUS_PRESENT;

  owbm_pkg::out_t tick_results_q [$];
  line_mode_t line_mode = LINE_HIGH;
  int errors = 0;
  int n_ticks = 0;
  int n_resets = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_done = 0;
  int n_settings = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_clock = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  row_t plan [NROWS] = '{
    '{'{1'b0, owbm_pkg::FUNC_RESET, 8'h00, 1'b1}, LINE_HIGH, 1'b0, 1'b1, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_NONE, 8'hFF, 1'b0}, LINE_LOW, 1'b0, 1'b1, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_RESET, 8'h00, 1'b1}, LINE_HIGH, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b1, 8'h00, owbm_pkg::STATUS_NO_DEV, 8'h00}},
    '{'{1'b1, owbm_pkg::FUNC_RESET, 8'h00, 1'b0}, LINE_LOW, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b1, 8'h00, owbm_pkg::STATUS_SHORT, 8'h00}},
    '{'{1'b1, owbm_pkg::FUNC_RESET, 8'h00, 1'b0}, LINE_PULSE, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b1, 8'h00, owbm_pkg::STATUS_PRESENT, 8'h00}},
    '{'{1'b1, owbm_pkg::FUNC_READ, 8'h00, 1'b0}, LINE_LOW, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b1, 8'h00, owbm_pkg::STATUS_PRESENT, 8'h00}},
    '{'{1'b1, owbm_pkg::FUNC_READ, 8'h00, 1'b1}, LINE_HIGH, 1'b0, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'h00, 1'b1}, LINE_HIGH, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'hFF, 1'b0}, LINE_LOW, 1'b0, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'hA5, 1'b1}, LINE_RAND, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_READ, 8'h3C, 1'b0}, LINE_RAND, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'h5A, 1'b0}, LINE_PULSE, 1'b0, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_RESET, 8'hFF, 1'b1}, LINE_RAND, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_READ, 8'h00, 1'b1}, LINE_RAND, 1'b0, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_RESET, 8'h00, 1'b0}, LINE_PULSE, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'h80, 1'b1}, LINE_RAND, 1'b0, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_WRITE, 8'h01, 1'b0}, LINE_RAND, 1'b1, 1'b0, QUIET},
    '{'{1'b1, owbm_pkg::FUNC_READ, 8'hFF, 1'b1}, LINE_HIGH, 1'b0, 1'b0, QUIET}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] dallas_crc8(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c[0] ^ data[k]) ? ((c >> 1) ^ owbm_pkg::CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // one bus tick: advances the local state and returns what the block reports
  function automatic owbm_pkg::out_t bus_tick_result(input owbm_pkg::in_t t);
    owbm_pkg::out_t r;
    int n;
    int slot;
    int span;
    int sample_at;
    int low_len;
    r = '0;
    if (bus_phase == owbm_pkg::PH_IDLE && t.cmd_valid &&
        (t.func == owbm_pkg::FUNC_RESET || t.func == owbm_pkg::FUNC_WRITE ||
         t.func == owbm_pkg::FUNC_READ)) begin
      slot_cnt = '0;
      bit_cnt = '0;
      if (t.func == owbm_pkg::FUNC_RESET) begin
        bus_phase = owbm_pkg::PH_RLOW;
        crc_q = '0;
      end else if (t.func == owbm_pkg::FUNC_WRITE) begin
        bus_phase = owbm_pkg::PH_WRITE;
        shift_q = t.tx_byte;
      end else begin
        bus_phase = owbm_pkg::PH_READ;
        shift_q = '0;
      end
    end
    r.busy_res = (bus_phase != owbm_pkg::PH_IDLE);
    n = slot_cnt;
    slot = timing_regs[owbm_pkg::REG_SLOT_TOTAL];
    case (bus_phase)
      owbm_pkg::PH_RLOW: begin
        r.line_low = 1'b1;
        if (n + 1 >= timing_regs[owbm_pkg::REG_RESET_LOW]) begin
          bus_phase = owbm_pkg::PH_RWAIT;
          slot_cnt = '0;
        end else begin
          slot_cnt++;
        end
      end
      owbm_pkg::PH_RWAIT: begin
        if (n + 1 >= timing_regs[owbm_pkg::REG_PRESENCE_SMPL]) begin
          if (t.line_in) begin
            status_q = owbm_pkg::STATUS_NO_DEV;
            r.done_res = 1'b1;
            bus_phase = owbm_pkg::PH_IDLE;
          end else begin
            bus_phase = owbm_pkg::PH_RTAIL;
          end
          slot_cnt = '0;
        end else begin
          slot_cnt++;
        end
      end
      owbm_pkg::PH_RTAIL: begin
        if (n + 1 >= timing_regs[owbm_pkg::REG_RESET_TAIL]) begin
          status_q = t.line_in ? owbm_pkg::STATUS_PRESENT : owbm_pkg::STATUS_SHORT;
          r.done_res = 1'b1;
          bus_phase = owbm_pkg::PH_IDLE;
          slot_cnt = '0;
        end else begin
          slot_cnt++;
        end
      end
      owbm_pkg::PH_WRITE: begin
        low_len = shift_q[0] ? timing_regs[owbm_pkg::REG_WRITE_ONE_LOW] :
                               timing_regs[owbm_pkg::REG_WRITE_ZERO_LOW];
        r.line_low = (n < low_len);
        if (n + 1 >= slot) begin
          shift_q = shift_q >> 1;
          slot_cnt = '0;
          if (bit_cnt == 3'd7) begin
            r.done_res = 1'b1;
            bus_phase = owbm_pkg::PH_IDLE;
            bit_cnt = '0;
          end else begin
            bit_cnt++;
          end
        end else begin
          slot_cnt++;
        end
      end
      owbm_pkg::PH_READ: begin
        span = (slot < 1) ? 1 : slot;
        sample_at = (timing_regs[owbm_pkg::REG_READ_SAMPLE] < span) ?
                    timing_regs[owbm_pkg::REG_READ_SAMPLE] : span - 1;
        r.line_low = (n < timing_regs[owbm_pkg::REG_READ_LOW]);
        if (n == sample_at) shift_q = {t.line_in, shift_q[7:1]};
        if (n + 1 >= slot) begin
          slot_cnt = '0;
          if (bit_cnt == 3'd7) begin
            rx_q = shift_q;
            crc_q = dallas_crc8(crc_q, shift_q);
            r.done_res = 1'b1;
            bus_phase = owbm_pkg::PH_IDLE;
            bit_cnt = '0;
          end else begin
            bit_cnt++;
          end
        end else begin
          slot_cnt++;
        end
      end
      default: begin
      end
    endcase
    r.rx_byte = rx_q;
    r.status = status_q;
    r.crc_value = crc_q;
    return r;
  endfunction

  function automatic logic line_for_phase();
    case (line_mode)
      LINE_HIGH: return 1'b1;
      LINE_LOW: return 1'b0;
      LINE_PULSE: return (bus_phase == owbm_pkg::PH_RTAIL);
      default: return 1'(($urandom_range(0, 1)));
    endcase
  endfunction

  task automatic send_tick(input owbm_pkg::in_t t, input bit typed,
                           input owbm_pkg::out_t want);
    owbm_pkg::out_t r;
    bit was_idle;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    was_idle = (bus_phase == owbm_pkg::PH_IDLE);
    r = bus_tick_result(t);
    if (was_idle && r.busy_res) begin
      if (t.func == owbm_pkg::FUNC_RESET) n_resets++;
      else if (t.func == owbm_pkg::FUNC_WRITE) n_writes++;
      else n_reads++;
    end
    if (r.done_res) n_done++;
    tick_results_q.push_back((typed && (!r.busy_res || r.done_res)) ? want : r);
    n_ticks++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 20);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_results_q.size() != 0);
  endtask

  task automatic run_command(input owbm_pkg::in_t first, input line_mode_t mode,
                             input bit poke, input bit pause, input bit typed,
                             input owbm_pkg::out_t want);
    owbm_pkg::in_t fill;
    line_mode = mode;
    send_tick(first, typed, want);
    if (pause) drain_results();
    while (bus_phase != owbm_pkg::PH_IDLE) begin
      fill.cmd_valid = poke ? 1'($urandom_range(0, 1)) : 1'b0;
      fill.func = 2'($urandom_range(0, 3));
      fill.tx_byte = 8'($urandom_range(0, 255));
      fill.line_in = line_for_phase();
      send_tick(fill, typed, want);
    end
  endtask

  // timings change only with no command on the bus and nothing in flight
  task automatic load_timing();
    drain_results();
    for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= owbm_pkg::REG_IDX_W'(i);
      cfg_data <= timing_next[i];
      do @(posedge clk); while (!cfg_ready);
      timing_regs[i] = timing_next[i];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic random_command(input bit pause);
    owbm_pkg::in_t first;
    int pick;
    line_mode_t mode;
    pick = $urandom_range(0, 19);
    first.cmd_valid = (pick != 0);
    first.func = 2'($urandom_range(0, 3));
    if (pick == 1) first.func = owbm_pkg::FUNC_NONE;
    else if (pick > 1 && pick < 7) first.func = owbm_pkg::FUNC_RESET;
    else if (pick >= 7 && pick < 13) first.func = owbm_pkg::FUNC_WRITE;
    else if (pick >= 13) first.func = owbm_pkg::FUNC_READ;
    first.tx_byte = 8'($urandom_range(0, 255));
    first.line_in = 1'($urandom_range(0, 1));
    mode = line_mode_t'($urandom_range(0, 3));
    if (first.func == owbm_pkg::FUNC_READ && $urandom_range(0, 2) != 0) mode = LINE_RAND;
    run_command(first, mode, 1'($urandom_range(0, 1)), pause, 1'b0, QUIET);
  endtask

  // receiver: rotating stall patterns, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    stall_clock++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((stall_clock / 200) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_clock % 3 == 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    owbm_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        $error("result transaction with no tick pending");
        errors++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("line_low", want.line_low, out_data.line_low);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("status", want.status, out_data.status);
        check_field("crc_value", want.crc_value, out_data.crc_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no transaction for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_no;
    int random_start;
    int ncmds;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    timing_next = '{10'd3, 10'd2, 10'd2, 10'd1, 10'd3, 10'd1, 10'd2, 10'd4};
    load_timing();
    for (int i = 0; i < NROWS; i++)
      run_command(plan[i].first, plan[i].mode, plan[i].poke, 1'b0, plan[i].typed, plan[i].want);

    phase_no = 0;
    random_start = n_ticks;
    while (phase_no < 4 || n_ticks - random_start < RANDOM_TICKS) begin
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
        case (phase_no)
          0: timing_next[i] = '0;
          1: timing_next[i] = 10'd1;
          default: timing_next[i] = owbm_pkg::CFG_W'($urandom_range(0, 12));
        endcase
      end
      if (phase_no > 1)
        timing_next[owbm_pkg::REG_SLOT_TOTAL] = owbm_pkg::CFG_W'($urandom_range(0, 10));
      load_timing();
      ncmds = $urandom_range(8, 16);
      for (int k = 0; k < ncmds; k++) begin
        if (phase_no == 1 && k == 3) hold_req = 1'b1;
        random_command(phase_no == 2 && k == 1);
      end
      phase_no++;
    end

    // low times and read sample at full scale, far beyond a short slot
    timing_next = '{10'd4, 10'd3, 10'd3, '1, '1, '1, '1, 10'd6};
    load_timing();
    run_command(owbm_pkg::in_t'{1'b1, owbm_pkg::FUNC_RESET, 8'h00, 1'b0}, LINE_PULSE,
                1'b1, 1'b0, 1'b0, QUIET);
    run_command(owbm_pkg::in_t'{1'b1, owbm_pkg::FUNC_WRITE, 8'hC3, 1'b1}, LINE_RAND,
                1'b1, 1'b0, 1'b0, QUIET);
    run_command(owbm_pkg::in_t'{1'b1, owbm_pkg::FUNC_READ, 8'h00, 1'b1}, LINE_RAND,
                1'b1, 1'b0, 1'b0, QUIET);

    drain_results();
    repeat (4) @(posedge clk);
    if (tick_results_q.size() != 0) begin
      $error("%0d tick results never arrived", tick_results_q.size());
      errors++;
    end
    $display("covered %0d ticks: %0d resets, %0d writes, %0d reads, %0d finished",
             n_ticks, n_resets, n_writes, n_reads, n_done);
    $display("across %0d timing settings, %0d mismatches", n_settings, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/owbm_pkg.sv
design/owbm_regs.sv
design/one_wire_bus_master.sv
tb/one_wire_bus_master_tb.sv
